>>> rtl/core/frirp_pkg.sv
// ----------------------------------------------------------------------------
// frirp_pkg
// Shared types and constants of the fuel rate interpolator.
// ----------------------------------------------------------------------------
package frirp_pkg;

  // configuration register indexes
  typedef logic [2:0] cfg_idx_t;
  localparam cfg_idx_t CFG_FUEL_MODE      = 3'd0;
  localparam cfg_idx_t CFG_CAPACITY_KW    = 3'd1;
  localparam cfg_idx_t CFG_FUEL_INTERCEPT = 3'd2;
  localparam cfg_idx_t CFG_FUEL_SLOPE     = 3'd3;
  localparam cfg_idx_t CFG_ENTRIES_USED   = 3'd4;

  localparam logic CMD_LOAD    = 1'b0;
  localparam logic MODE_LOOKUP = 1'b1;

  localparam int CfgDataW  = 24;
  localparam int AccW      = 58;
  localparam int OpaW      = 41;
  localparam int MulBW     = 17;
  localparam int CntW      = 6;
  localparam int RatioSteps = 16;
  localparam int QuotSteps  = 41;
  localparam int LinShift   = 20;
  localparam int LutShift   = 4;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_ZERO,
    OP_LINEAR,
    OP_LOOKUP
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [4:0]  idx;
    logic [16:0] ratio;
    logic [23:0] rate;
    logic [23:0] prod;
    logic [23:0] hours;
  } item_t;

  typedef struct packed {
    logic        mode;
    logic [23:0] capacity;
    logic [15:0] intercept;
    logic [15:0] slope;
    logic [5:0]  entries_used;
  } cfg_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_LIN0,
    ST_LIN1,
    ST_RATIO,
    ST_DIV,
    ST_EDGE,
    ST_SRD,
    ST_SCMP,
    ST_X0,
    ST_X1,
    ST_X2,
    ST_NUM,
    ST_QDIV,
    ST_ADJ,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_DONE_W
  } st_t;

  function automatic logic [31:0] sat32(input logic [AccW-1:0] v);
    logic [31:0] r;
    if (v[AccW-1:32] != '0) begin
      r = 32'hFFFF_FFFF;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/core/frirp_front.sv
// ----------------------------------------------------------------------------
// frirp_front
// Input side: classifies each item and holds it in a two-entry queue.
// ----------------------------------------------------------------------------
module frirp_front
  import frirp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        mode,
  input  logic        push,
  output logic        full,
  input  logic        command,
  input  logic [4:0]  entry_index,
  input  logic [16:0] entry_load_ratio,
  input  logic [23:0] entry_fuel_rate,
  input  logic [23:0] power_kw,
  input  logic [23:0] step_hours,
  input  logic        running,
  output logic        q_valid,
  output item_t       q_head,
  input  logic        q_pop
);

  item_t      q_mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push_xfer;
  item_t      item;

  always_comb begin
    item.idx   = entry_index;
    item.ratio = entry_load_ratio;
    item.rate  = entry_fuel_rate;
    item.prod  = power_kw;
    item.hours = step_hours;
    if (command == CMD_LOAD) begin
      item.op = OP_LOAD;
    end else if (!running) begin
      item.op = OP_ZERO;
    end else if (mode == MODE_LOOKUP) begin
      item.op = OP_LOOKUP;
    end else begin
      item.op = OP_LINEAR;
    end
  end

  assign full      = (count_r == 2'd2);
  assign q_valid   = (count_r != 2'd0);
  assign q_head    = q_mem_r[rd_ptr_r];
  assign push_xfer = push && !full;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push_xfer;
    rd_ptr_nxt = rd_ptr_r ^ (q_pop && q_valid);
    count_nxt  = count_r + 2'(push_xfer) - 2'(q_pop && q_valid);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_xfer) begin
      q_mem_r[wr_ptr_r] <= item;
    end
  end

endmodule

>>> rtl/core/frirp_back.sv
// ----------------------------------------------------------------------------
// frirp_back
// Execution side: table memory, search sequencer, shared multiplier and
// bit-serial dividers, and the result register.
// ----------------------------------------------------------------------------
module frirp_back
  import frirp_pkg::*;
#(
  parameter int TABLE_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        q_valid,
  input  item_t       q_head,
  output logic        q_pop,
  output logic        out_valid,
  output logic [31:0] out_data,
  input  logic        out_pop
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int NW = $clog2(TABLE_DEPTH + 1);

  logic [16:0] bp_mem [TABLE_DEPTH];
  logic [23:0] rt_mem [TABLE_DEPTH];
  logic [16:0] bp_q;
  logic [23:0] rt_q;

  st_t state_r, state_nxt;

  logic [23:0]     prod_r, prod_nxt;
  logic [23:0]     hours_r, hours_nxt;
  logic            lin_r, lin_nxt;
  logic [AW-1:0]   seg_r, seg_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic [23:0]     rem_r, rem_nxt;
  logic [15:0]     ratio_r, ratio_nxt;
  logic [16:0]     qrem_r, qrem_nxt;
  logic [16:0]     x0_r, x0_nxt, x1_r, x1_nxt, dmag_r, dmag_nxt;
  logic [23:0]     y0_r, y0_nxt, y1_r, y1_nxt;
  logic            neg_r, neg_nxt;
  logic [AccW-1:0] acc_r, acc_nxt, t_r, t_nxt;
  logic [OpaW-1:0] opa_r, opa_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [31:0]     out_data_r, out_data_nxt;

  logic [OpaW-1:0]  mul_a;
  logic [MulBW-1:0] mul_b;
  logic [AccW-1:0]  mul_p;
  logic [AW-1:0]    rd_addr;
  logic             mem_we;
  logic [NW-1:0]    n_cl;
  logic             seg_last;
  logic             edge_case;
  logic             slot_free;

  logic [24:0] rem2;
  logic        rge;
  logic [17:0] qt;
  logic        qge;
  logic signed [17:0] den, dx;
  logic signed [24:0] dy;
  logic [16:0] dx_mag;
  logic [23:0] dy_mag;
  logic signed [42:0] res;

  assign mul_p = AccW'(mul_a) * AccW'(mul_b);

  always_comb begin
    if (cfg.entries_used < 6'd2) begin
      n_cl = NW'(2);
    end else if (32'(cfg.entries_used) > TABLE_DEPTH) begin
      n_cl = NW'(TABLE_DEPTH);
    end else begin
      n_cl = NW'(cfg.entries_used);
    end
  end

  assign seg_last  = (32'(seg_r) + 32'd2) >= 32'(n_cl);
  assign edge_case = (prod_r == '0) || (prod_r >= cfg.capacity);
  assign slot_free = !out_valid_r || out_pop;

  // one restoring step of production*65536/capacity
  assign rem2      = {rem_r, 1'b0};
  assign rge       = rem2 >= {1'b0, cfg.capacity};
  assign ratio_nxt = (state_r == ST_DIV) ? {ratio_r[14:0], rge} : ratio_r;

  // one restoring step of the interpolation quotient
  assign qt  = {qrem_r, acc_r[OpaW-1]};
  assign qge = qt >= {1'b0, dmag_r};

  always_comb begin
    den    = $signed({1'b0, x1_r}) - $signed({1'b0, x0_r});
    dx     = $signed({2'b00, ratio_r}) - $signed({1'b0, x0_r});
    dy     = $signed({1'b0, y1_r}) - $signed({1'b0, y0_r});
    dx_mag = dx[17] ? 17'(-dx) : dx[16:0];
    dy_mag = dy[24] ? 24'(-dy) : dy[23:0];
    if (neg_r) begin
      res = $signed({19'd0, y0_r}) - $signed({2'b00, acc_r[OpaW-1:0]});
    end else begin
      res = $signed({19'd0, y0_r}) + $signed({2'b00, acc_r[OpaW-1:0]});
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          case (q_head.op)
            OP_LOAD:   state_nxt = ST_IDLE;
            OP_ZERO:   state_nxt = ST_DONE_W;
            OP_LINEAR: state_nxt = ST_LIN0;
            OP_LOOKUP: state_nxt = ST_RATIO;
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_LIN0:  state_nxt = ST_LIN1;
      ST_LIN1:  state_nxt = ST_MUL_LO;
      ST_RATIO: state_nxt = edge_case ? ST_EDGE : ST_DIV;
      ST_DIV: begin
        if (cnt_r == CntW'(1)) begin
          state_nxt = (ratio_nxt == '0) ? ST_EDGE : ST_SRD;
        end
      end
      ST_EDGE:  state_nxt = ST_MUL_LO;
      ST_SRD:   state_nxt = seg_last ? ST_X0 : ST_SCMP;
      ST_SCMP:  state_nxt = (bp_q < {1'b0, ratio_r}) ? ST_SRD : ST_X0;
      ST_X0:    state_nxt = ST_X1;
      ST_X1:    state_nxt = ST_X2;
      ST_X2:    state_nxt = ST_NUM;
      ST_NUM:   state_nxt = (den == '0) ? ST_MUL_LO : ST_QDIV;
      ST_QDIV:  state_nxt = (cnt_r == CntW'(1)) ? ST_ADJ : ST_QDIV;
      ST_ADJ:   state_nxt = ST_MUL_LO;
      ST_MUL_LO: state_nxt = ST_MUL_HI;
      ST_MUL_HI: state_nxt = ST_DONE_W;
      ST_DONE_W: state_nxt = slot_free ? ST_IDLE : ST_DONE_W;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    q_pop         = 1'b0;
    mem_we        = 1'b0;
    rd_addr       = '0;
    mul_a         = '0;
    mul_b         = '0;
    prod_nxt      = prod_r;
    hours_nxt     = hours_r;
    lin_nxt       = lin_r;
    seg_nxt       = seg_r;
    cnt_nxt       = cnt_r;
    rem_nxt       = rem_r;
    qrem_nxt      = qrem_r;
    x0_nxt        = x0_r;
    x1_nxt        = x1_r;
    y0_nxt        = y0_r;
    y1_nxt        = y1_r;
    dmag_nxt      = dmag_r;
    neg_nxt       = neg_r;
    acc_nxt       = acc_r;
    t_nxt         = t_r;
    opa_nxt       = opa_r;
    out_valid_nxt = out_valid_r && !out_pop;
    out_data_nxt  = out_data_r;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          prod_nxt  = q_head.prod;
          hours_nxt = q_head.hours;
          lin_nxt   = (q_head.op != OP_LOOKUP);
          acc_nxt   = '0;
          mem_we    = (q_head.op == OP_LOAD) && (32'(q_head.idx) < TABLE_DEPTH);
        end
      end
      ST_LIN0: begin
        mul_a   = OpaW'(cfg.capacity);
        mul_b   = MulBW'(cfg.intercept);
        acc_nxt = mul_p;
      end
      ST_LIN1: begin
        mul_a   = OpaW'(prod_r);
        mul_b   = MulBW'(cfg.slope);
        opa_nxt = OpaW'(acc_r + mul_p);
      end
      ST_RATIO: begin
        rd_addr = (prod_r == '0) ? '0 : AW'(n_cl - NW'(1));
        rem_nxt = prod_r;
        cnt_nxt = CntW'(RatioSteps);
        seg_nxt = '0;
      end
      ST_DIV: begin
        rem_nxt = rge ? 24'(rem2 - {1'b0, cfg.capacity}) : rem2[23:0];
        cnt_nxt = cnt_r - CntW'(1);
      end
      ST_EDGE: begin
        opa_nxt = OpaW'(rt_q);
      end
      ST_SRD: begin
        rd_addr = AW'(seg_r + AW'(1));
      end
      ST_SCMP: begin
        if (bp_q < {1'b0, ratio_r}) begin
          seg_nxt = AW'(seg_r + AW'(1));
        end
      end
      ST_X0: begin
        rd_addr = seg_r;
      end
      ST_X1: begin
        rd_addr = AW'(seg_r + AW'(1));
        x0_nxt  = bp_q;
        y0_nxt  = rt_q;
      end
      ST_X2: begin
        x1_nxt = bp_q;
        y1_nxt = rt_q;
      end
      ST_NUM: begin
        mul_a    = OpaW'(dy_mag);
        mul_b    = dx_mag;
        acc_nxt  = mul_p;
        neg_nxt  = dx[17] ^ dy[24] ^ den[17];
        dmag_nxt = den[17] ? 17'(-den) : den[16:0];
        qrem_nxt = '0;
        cnt_nxt  = CntW'(QuotSteps);
        if (den == '0) begin
          opa_nxt = OpaW'(y0_r);
        end
      end
      ST_QDIV: begin
        qrem_nxt = qge ? 17'(qt - {1'b0, dmag_r}) : qt[16:0];
        acc_nxt  = AccW'({acc_r[OpaW-2:0], qge});
        cnt_nxt  = cnt_r - CntW'(1);
      end
      ST_ADJ: begin
        if (res[42]) begin
          opa_nxt = '0;
        end else if (res > 43'sh0FF_FFFF) begin
          opa_nxt = OpaW'(24'hFF_FFFF);
        end else begin
          opa_nxt = OpaW'(res[23:0]);
        end
      end
      ST_MUL_LO: begin
        mul_a = opa_r;
        mul_b = MulBW'(hours_r[11:0]);
        t_nxt = mul_p;
      end
      ST_MUL_HI: begin
        mul_a   = opa_r;
        mul_b   = MulBW'(hours_r[23:12]);
        acc_nxt = mul_p + (t_r >> 12);
      end
      ST_DONE_W: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = lin_r ? sat32(acc_r >> LinShift) : sat32(acc_r >> LutShift);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r     <= prod_nxt;
    hours_r    <= hours_nxt;
    lin_r      <= lin_nxt;
    seg_r      <= seg_nxt;
    cnt_r      <= cnt_nxt;
    rem_r      <= rem_nxt;
    ratio_r    <= ratio_nxt;
    qrem_r     <= qrem_nxt;
    x0_r       <= x0_nxt;
    x1_r       <= x1_nxt;
    y0_r       <= y0_nxt;
    y1_r       <= y1_nxt;
    dmag_r     <= dmag_nxt;
    neg_r      <= neg_nxt;
    acc_r      <= acc_nxt;
    t_r        <= t_nxt;
    opa_r      <= opa_nxt;
    out_data_r <= out_data_nxt;
  end

  // table memories, one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      bp_mem[AW'(q_head.idx)] <= q_head.ratio;
      rt_mem[AW'(q_head.idx)] <= q_head.rate;
    end
    bp_q <= bp_mem[rd_addr];
    rt_q <= rt_mem[rd_addr];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> rtl/core/fuel_rate_interpolator_core.sv
// ----------------------------------------------------------------------------
// fuel_rate_interpolator_core
// Fuel burned by a generator over one time step, linear model or table
// lookup with piecewise linear interpolation.
// ----------------------------------------------------------------------------
// Items pass through a two-deep queue to a sequential execution unit that
// handles one item at a time. A lookup step skips the segment search and
// takes the rate of an end entry when the production is zero or reaches
// the capacity, or when a small production divides down to a load ratio of
// zero; otherwise it searches the table for its segment and interpolates,
// and a segment with equal breakpoints skips the quotient. The time goes to
// the bit-serial ratio divider, the bit-serial interpolation divider, the
// segment search on the single table read port, and the shared multiplier.
// The result register lets the next item start while a result waits to be
// popped.
module fuel_rate_interpolator_core
  import frirp_pkg::*;
#(
  parameter int TABLE_DEPTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  logic                in_command,
  input  logic [4:0]          in_entry_index,
  input  logic [16:0]         in_entry_load_ratio,
  input  logic [23:0]         in_entry_fuel_rate,
  input  logic [23:0]         in_power_kw,
  input  logic [23:0]         in_step_hours,
  input  logic                in_running,
  output logic                out_empty,
  input  logic                out_pop,
  output logic [31:0]         out_fuel_litres,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  cfg_idx_t            cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  cfg_t  cfg_r, cfg_nxt;
  logic  q_valid;
  logic  q_pop;
  item_t q_head;
  logic  out_valid;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_FUEL_MODE:      cfg_nxt.mode         = cfg_data[0];
        CFG_CAPACITY_KW:    cfg_nxt.capacity     = cfg_data[23:0];
        CFG_FUEL_INTERCEPT: cfg_nxt.intercept    = cfg_data[15:0];
        CFG_FUEL_SLOPE:     cfg_nxt.slope        = cfg_data[15:0];
        CFG_ENTRIES_USED:   cfg_nxt.entries_used = cfg_data[5:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode         <= 1'b0;
      cfg_r.capacity     <= 24'd256;
      cfg_r.intercept    <= 16'd0;
      cfg_r.slope        <= 16'd0;
      cfg_r.entries_used <= 6'd2;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  frirp_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .mode             (cfg_r.mode),
    .push             (in_push),
    .full             (in_full),
    .command          (in_command),
    .entry_index      (in_entry_index),
    .entry_load_ratio (in_entry_load_ratio),
    .entry_fuel_rate  (in_entry_fuel_rate),
    .power_kw         (in_power_kw),
    .step_hours       (in_step_hours),
    .running          (in_running),
    .q_valid          (q_valid),
    .q_head           (q_head),
    .q_pop            (q_pop)
  );

  frirp_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_data  (out_fuel_litres),
    .out_pop   (out_pop)
  );

  assign out_empty = !out_valid;

endmodule

>>> rtl/core/frirp_checker.sv
// ----------------------------------------------------------------------------
// frirp_checker
// Port-level checks of the fuel rate interpolator, bound to the top level.
// ----------------------------------------------------------------------------
module frirp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_push,
  input logic        in_full,
  input logic        out_empty,
  input logic        out_pop,
  input logic [31:0] out_fuel_litres,
  input logic        cfg_ready
);

  // a waiting result holds until its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_fuel_litres))
    else $error("result changed before transfer");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> out_empty && !in_full)
    else $error("queues not empty after reset");

  // queue fills only by a transfer on the input side
  a_full_needs_push: assert property (@(posedge clk) disable iff (!rst_n)
    !in_full && !(in_push && !in_full) |=> !in_full)
    else $error("input queue filled without a transfer");

  // an offered result carries defined bits
  a_result_known: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> !$isunknown(out_fuel_litres))
    else $error("result has unknown bits");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("configuration port not ready");

endmodule

bind fuel_rate_interpolator_core frirp_checker u_frirp_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_push         (in_push),
  .in_full         (in_full),
  .out_empty       (out_empty),
  .out_pop         (out_pop),
  .out_fuel_litres (out_fuel_litres),
  .cfg_ready       (cfg_ready)
);
